// ===== rtl/core/tap_on_lone_release_remapper_core_defines.svh =====
// ---------------------------------------------------------------------------
// Tap remapper assertion macros
// Concurrent check helpers; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef TAP_ON_LONE_RELEASE_REMAPPER_CORE_DEFINES_SVH
`define TAP_ON_LONE_RELEASE_REMAPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TRL_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("tap remapper check failed");
`define TRL_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("tap remapper check failed");
`else
`define TRL_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define TRL_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ===== rtl/core/trl_pkg.sv =====
// ---------------------------------------------------------------------------
// Tap remapper package
// Shared types, event codes and table sizing.
// ---------------------------------------------------------------------------
package trl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [15:0] TYPE_SYNC = 16'd0;
  localparam logic [15:0] TYPE_KEY = 16'd1;
  localparam logic [15:0] TYPE_MISC = 16'd4;
  localparam logic [15:0] MISC_SCAN = 16'd4;
  localparam logic signed [31:0] VAL_PRESS = 32'sd1;
  localparam logic signed [31:0] VAL_REPEAT = 32'sd2;

  localparam logic [23:0] TIMEOUT_RESET = 24'd220000;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAP_LENGTH = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [15:0]       ev_type;
    logic [15:0]       ev_code;
    logic signed [31:0] ev_value;
    logic [31:0]       stamp_sec;
    logic [19:0]       stamp_usec;
    logic [5:0]        entry_index;
    logic [15:0]       bind_key;
    logic [15:0]       bind_tap_key;
    logic [15:0]       bind_modifier;
  } evt_item_t;

  typedef struct packed {
    logic [15:0] out_type;
    logic [15:0] out_code;
    logic        out_value;
    logic        run_last;
  } rpt_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tap_key;
    logic [15:0] modifier;
  } bind_entry_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [5:0]  index;
    bind_entry_t entry;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    STEP_MOD_DOWN,
    STEP_TAP_DOWN,
    STEP_TAP_UP,
    STEP_MOD_UP,
    STEP_SYNC
  } tap_step_t;

endpackage

// ===== rtl/core/trl_front.sv =====
// ---------------------------------------------------------------------------
// Tap remapper front end
// Tracks scan and press state, qualifies releases, queues commands.
// ---------------------------------------------------------------------------
module trl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_stall,
  input  trl_pkg::evt_item_t evt,
  input  logic [23:0]        timeout_us,
  input  logic               q_full,
  output logic               q_push,
  output trl_pkg::cmd_t      q_cmd
);
  import trl_pkg::*;

  localparam logic signed [24:0] USEC_PER_SEC = 25'sd1000000;
  localparam logic signed [32:0] SEC_ONE = 33'sd1;
  localparam logic signed [32:0] SEC_ZERO = 33'sd0;
  localparam logic signed [32:0] SEC_MINUS_ONE = -33'sd1;

  logic        scan_armed;
  logic [31:0] current_scan;
  logic [31:0] pressed_scan;
  logic [31:0] press_sec;
  logic [19:0] press_usec;

  logic                accept;
  logic                is_scan;
  logic                key_edge;
  logic                is_press;
  logic                in_time;
  logic                lookup;
  logic signed [32:0]  sec_delta;
  logic signed [20:0]  usec_diff;
  logic signed [24:0]  elapsed;

  assign evt_stall = q_full;
  assign accept = evt_valid && !evt_stall;

  assign is_scan = (evt.opcode == OP_EVENT) && (evt.ev_type == TYPE_MISC)
                   && (evt.ev_code == MISC_SCAN);
  assign key_edge = (evt.opcode == OP_EVENT) && !is_scan && (evt.ev_type == TYPE_KEY)
                    && scan_armed && (evt.ev_value != VAL_REPEAT);
  assign is_press = evt.ev_value == VAL_PRESS;

  assign sec_delta = $signed({1'b0, evt.stamp_sec}) - $signed({1'b0, press_sec});
  assign usec_diff = $signed({1'b0, evt.stamp_usec}) - $signed({1'b0, press_usec});

  always_comb begin
    elapsed = 25'(usec_diff);
    if (sec_delta == SEC_ONE) begin
      elapsed = 25'(usec_diff) + USEC_PER_SEC;
    end else if (sec_delta == SEC_MINUS_ONE) begin
      elapsed = 25'(usec_diff) - USEC_PER_SEC;
    end
    if (timeout_us == 24'd0) begin
      in_time = 1'b1;
    end else if (sec_delta < SEC_MINUS_ONE) begin
      in_time = 1'b1;
    end else if (sec_delta == SEC_ONE || sec_delta == SEC_ZERO || sec_delta == SEC_MINUS_ONE) begin
      in_time = elapsed <= $signed({1'b0, timeout_us});
    end else begin
      in_time = 1'b0;
    end
  end

  assign lookup = key_edge && !is_press && (current_scan == pressed_scan) && in_time;

  always_comb begin
    q_push = accept && ((evt.opcode == OP_LOAD) || lookup);
    q_cmd.index = evt.entry_index;
    if (evt.opcode == OP_LOAD) begin
      q_cmd.kind = CMD_LOAD;
      q_cmd.entry.key = evt.bind_key;
      q_cmd.entry.tap_key = evt.bind_tap_key;
      q_cmd.entry.modifier = evt.bind_modifier;
    end else begin
      q_cmd.kind = CMD_LOOKUP;
      q_cmd.entry.key = evt.ev_code;
      q_cmd.entry.tap_key = 16'd0;
      q_cmd.entry.modifier = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_armed <= 1'b0;
      current_scan <= 32'd0;
      pressed_scan <= 32'd0;
      press_sec <= 32'd0;
      press_usec <= 20'd0;
    end else if (accept) begin
      if (is_scan) begin
        current_scan <= evt.ev_value;
        scan_armed <= 1'b1;
      end else if (key_edge) begin
        scan_armed <= 1'b0;
        if (is_press) begin
          press_sec <= evt.stamp_sec;
          press_usec <= evt.stamp_usec;
          pressed_scan <= current_scan;
        end
      end
    end
  end

endmodule

// ===== rtl/core/trl_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// Tap remapper command queue
// Two-entry queue between front end and back end.
// ---------------------------------------------------------------------------
module trl_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trl_pkg::cmd_t push_cmd,
  input  logic          pop,
  output trl_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import trl_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/trl_back.sv =====
// ---------------------------------------------------------------------------
// Tap remapper back end
// Owns the bind table, scans it on lookups and emits tap runs.
// ---------------------------------------------------------------------------
module trl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [6:0]         map_length,
  input  trl_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               rpt_valid,
  input  logic               rpt_stall,
  output trl_pkg::rpt_item_t rpt
);
  import trl_pkg::*;

  bind_entry_t mem [TABLE_DEPTH];
  bind_entry_t rd_data;

  back_state_t state;
  back_state_t state_next;
  tap_step_t   step;
  tap_step_t   step_next;

  logic [LIM_W-1:0] issue_idx;
  logic [LIM_W-1:0] limit;
  logic             pend;
  logic [15:0]      code;
  bind_entry_t      hit_entry;

  logic        mem_we;
  logic        rd_en;
  logic        hit;
  logic        more;
  logic        emit_fire;
  rpt_item_t   emit_item;

  assign limit = (LIM_W'(map_length) > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
                                                            : LIM_W'(map_length);
  assign more = issue_idx < limit;
  assign hit = pend && (rd_data.key == code);

  always_comb begin
    q_pop = (state == BK_IDLE) && !q_empty;
    mem_we = q_pop && (head.kind == CMD_LOAD) && (32'(head.index) < TABLE_DEPTH);
    rd_en = (state == BK_SCAN) && !hit && more;
    emit_fire = (state == BK_EMIT) && (!rpt_valid || !rpt_stall);
    emit_item.out_type = TYPE_KEY;
    emit_item.out_code = hit_entry.tap_key;
    emit_item.out_value = 1'b0;
    emit_item.run_last = 1'b0;
    case (step)
      STEP_MOD_DOWN: begin
        emit_item.out_code = hit_entry.modifier;
        emit_item.out_value = 1'b1;
      end
      STEP_TAP_DOWN: begin
        emit_item.out_value = 1'b1;
      end
      STEP_TAP_UP: begin
        emit_item.out_value = 1'b0;
      end
      STEP_MOD_UP: begin
        emit_item.out_code = hit_entry.modifier;
      end
      STEP_SYNC: begin
        emit_item.out_type = TYPE_SYNC;
        emit_item.out_code = 16'd0;
        emit_item.run_last = 1'b1;
      end
      default: begin
        emit_item.out_type = TYPE_SYNC;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_pop && head.kind == CMD_LOOKUP) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (hit) begin
          state_next = BK_EMIT;
        end else if (!more) begin
          state_next = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (emit_fire && step == STEP_SYNC) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    step_next = step;
    if (state == BK_SCAN && hit) begin
      step_next = (rd_data.modifier != 16'd0) ? STEP_MOD_DOWN : STEP_TAP_DOWN;
    end else if (emit_fire) begin
      case (step)
        STEP_MOD_DOWN: step_next = STEP_TAP_DOWN;
        STEP_TAP_DOWN: step_next = STEP_TAP_UP;
        STEP_TAP_UP: step_next = (hit_entry.modifier != 16'd0) ? STEP_MOD_UP : STEP_SYNC;
        STEP_MOD_UP: step_next = STEP_SYNC;
        default: step_next = STEP_SYNC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[TBL_AW'(head.index)] <= head.entry;
    end
    if (rd_en) begin
      rd_data <= mem[issue_idx[TBL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      step <= STEP_SYNC;
      pend <= 1'b0;
      issue_idx <= '0;
      rpt_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      if (q_pop && head.kind == CMD_LOOKUP) begin
        issue_idx <= '0;
        pend <= 1'b0;
      end else if (state == BK_SCAN) begin
        pend <= rd_en;
        if (rd_en) begin
          issue_idx <= issue_idx + LIM_W'(1);
        end
      end
      if (emit_fire) begin
        rpt_valid <= 1'b1;
      end else if (!rpt_stall) begin
        rpt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head.kind == CMD_LOOKUP) begin
      code <= head.entry.key;
    end
    if (state == BK_SCAN && hit) begin
      hit_entry <= rd_data;
    end
    if (emit_fire) begin
      rpt <= emit_item;
    end
  end

endmodule

// ===== rtl/core/tap_on_lone_release_remapper_core.sv =====
// ---------------------------------------------------------------------------
// Tap-on-lone-release remapper core
// Turns a lone press and release of a bound key into a tap of another key.
//
//   channel   dir  handshake          payload
//   evt       in   evt_valid/stall    trl_pkg::evt_item_t
//   rpt       out  rpt_valid/stall    trl_pkg::rpt_item_t
//   cfg       in   cfg_we             cfg_index, cfg_data
//
// Non-release events and load items pass the front end back to back while
// the queue has room. A qualified release scans the bind table at one entry
// per cycle over the single memory read port; a hit emits 3 or 5 reports.
// Reset is synchronous; the bind table holds no reset and needs no clearing.
// A stalled output holds the back end; the front end stalls when the queue fills.
// ---------------------------------------------------------------------------
`include "tap_on_lone_release_remapper_core_defines.svh"

module tap_on_lone_release_remapper_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_stall,
  input  trl_pkg::evt_item_t evt,
  output logic               rpt_valid,
  input  logic               rpt_stall,
  output trl_pkg::rpt_item_t rpt,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);
  import trl_pkg::*;

  logic [23:0] timeout_us;
  logic [6:0]  map_length;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RESET;
      map_length <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_us <= cfg_data;
        CFG_MAP_LENGTH: map_length <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  trl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt),
    .timeout_us (timeout_us),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  trl_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  trl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .map_length (map_length),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .rpt_valid  (rpt_valid),
    .rpt_stall  (rpt_stall),
    .rpt        (rpt)
  );

  `TRL_ASSERT_IMPLY(a_push_not_full, clk, rst, q_push, !q_full)
  `TRL_ASSERT_IMPLY(a_pop_not_empty, clk, rst, q_pop, !q_empty)
  `TRL_ASSERT_NEXT(a_rpt_hold, clk, rst, rpt_valid && rpt_stall, rpt_valid && $stable(rpt))

endmodule

// ===== tb/sv/tb_tap_on_lone_release_remapper_core.sv =====
// ---------------------------------------------------------------------------
// Tap remapper core testbench
// Loads the bind table, plays scan/press/scan/release sequences and noise
// through the event channel, predicts the emitted tap runs in a shadow model
// and compares every report transaction in order. Covers reset settings,
// lookup and timeout rules, event filtering, a long output hold-off and
// randomized phases under several register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tap_on_lone_release_remapper_core;
  import trl_pkg::*;

  localparam int unsigned GAP_MAX = 8;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam longint USEC_PER_SEC = 64'sd1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        evt_valid = 1'b0;
  logic        evt_stall;
  evt_item_t   evt_d = '0;
  logic        rpt_valid;
  rpt_item_t   rpt;
  logic        sink_stall = 1'b0;
  logic        long_hold = 1'b0;
  wire         rx_stall = sink_stall | long_hold;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  // shadow state of the block
  bind_entry_t        shadow_binds [TABLE_DEPTH];
  logic [23:0]        cfg_timeout = TIMEOUT_RESET;
  logic [6:0]         cfg_maplen = '0;
  logic               armed = 1'b0;
  logic [31:0]        scan_now = '0;
  logic [31:0]        scan_held = '0;
  logic [31:0]        held_sec = '0;
  logic [19:0]        held_usec = '0;

  rpt_item_t   tap_reports_q [$];
  bit          calm = 1'b0;
  longint      clock_us = 10 * USEC_PER_SEC;
  int unsigned items_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned taps_expected = 0;
  int unsigned cfg_writes = 0;
  int unsigned errors = 0;
  event        hold_ev;

  tap_on_lone_release_remapper_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt_d),
    .rpt_valid (rpt_valid),
    .rpt_stall (rx_stall),
    .rpt       (rpt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rpt_item_t tap_event(input logic [15:0] ty, input logic [15:0] code,
                                          input logic val, input logic last);
    rpt_item_t r;
    r.out_type = ty;
    r.out_code = code;
    r.out_value = val;
    r.run_last = last;
    return r;
  endfunction

  task automatic predict_taps(input evt_item_t it);
    int unsigned lim;
    int          hit;
    longint      sec_delta;
    longint      elapsed;
    bind_entry_t b;
    if (it.opcode == OP_LOAD) begin
      shadow_binds[it.entry_index] = '{key: it.bind_key, tap_key: it.bind_tap_key,
                                       modifier: it.bind_modifier};
      return;
    end
    if (it.ev_type == TYPE_MISC && it.ev_code == MISC_SCAN) begin
      scan_now = it.ev_value;
      armed = 1'b1;
      return;
    end
    if (it.ev_type != TYPE_KEY || !armed || it.ev_value == VAL_REPEAT) return;
    armed = 1'b0;
    if (it.ev_value == VAL_PRESS) begin
      held_sec = it.stamp_sec;
      held_usec = it.stamp_usec;
      scan_held = scan_now;
      return;
    end
    if (scan_now != scan_held) return;
    if (cfg_timeout != 0) begin
      sec_delta = longint'({32'd0, it.stamp_sec}) - longint'({32'd0, held_sec});
      if (sec_delta > 1) return;
      elapsed = longint'({44'd0, it.stamp_usec}) - longint'({44'd0, held_usec})
                + sec_delta * USEC_PER_SEC;
      if (elapsed > longint'({40'd0, cfg_timeout})) return;
    end
    lim = (cfg_maplen > TABLE_DEPTH) ? TABLE_DEPTH : cfg_maplen;
    hit = -1;
    for (int i = 0; i < lim; i++) begin
      if (hit < 0 && shadow_binds[i].key == it.ev_code) hit = i;
    end
    if (hit < 0) return;
    b = shadow_binds[hit];
    if (b.modifier != 0) tap_reports_q.push_back(tap_event(TYPE_KEY, b.modifier, 1'b1, 1'b0));
    tap_reports_q.push_back(tap_event(TYPE_KEY, b.tap_key, 1'b1, 1'b0));
    tap_reports_q.push_back(tap_event(TYPE_KEY, b.tap_key, 1'b0, 1'b0));
    if (b.modifier != 0) tap_reports_q.push_back(tap_event(TYPE_KEY, b.modifier, 1'b0, 1'b0));
    tap_reports_q.push_back(tap_event(TYPE_SYNC, 16'd0, 1'b0, 1'b1));
    taps_expected++;
  endtask

  task automatic match_report(input rpt_item_t got);
    rpt_item_t want;
    reports_seen++;
    if (tap_reports_q.size() == 0) begin
      $display("%0t: unexpected report type=%h code=%h value=%b last=%b",
               $time, got.out_type, got.out_code, got.out_value, got.run_last);
      errors++;
    end else begin
      want = tap_reports_q.pop_front();
      if (got.out_type !== want.out_type || got.out_code !== want.out_code ||
          got.out_value !== want.out_value || got.run_last !== want.run_last) begin
        $display("%0t: report mismatch expected type=%h code=%h value=%b last=%b",
                 $time, want.out_type, want.out_code, want.out_value, want.run_last);
        $display("%0t:                 actual   type=%h code=%h value=%b last=%b",
                 $time, got.out_type, got.out_code, got.out_value, got.run_last);
        errors++;
      end
    end
  endtask

  initial begin : report_sink
    int unsigned pause;
    forever begin
      @(posedge clk);
      if (!rst && rpt_valid && !rx_stall) begin
        match_report(rpt);
        pause = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (pause != 0) begin
          sink_stall <= 1'b1;
          repeat (pause) @(posedge clk);
          sink_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : hold_off
    forever begin
      @(hold_ev);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_tap_on_lone_release_remapper_core failed");
    $finish;
  end

  function automatic void stamp_of(input longint t, output logic [31:0] sec,
                                   output logic [19:0] usec);
    sec = 32'(t / USEC_PER_SEC);
    usec = 20'(t % USEC_PER_SEC);
  endfunction

  function automatic evt_item_t random_item();
    evt_item_t it;
    it.opcode = 1'($urandom);
    it.ev_type = 16'($urandom);
    it.ev_code = 16'($urandom);
    it.ev_value = $urandom;
    it.stamp_sec = $urandom;
    it.stamp_usec = 20'($urandom);
    it.entry_index = 6'($urandom);
    it.bind_key = 16'($urandom);
    it.bind_tap_key = 16'($urandom);
    it.bind_modifier = 16'($urandom);
    return it;
  endfunction

  function automatic evt_item_t scan_item(input logic [31:0] scan);
    evt_item_t it;
    it = random_item();
    it.opcode = OP_EVENT;
    it.ev_type = TYPE_MISC;
    it.ev_code = MISC_SCAN;
    it.ev_value = scan;
    return it;
  endfunction

  function automatic evt_item_t key_item(input logic [15:0] code,
                                         input logic signed [31:0] val, input longint t);
    evt_item_t it;
    it = random_item();
    it.opcode = OP_EVENT;
    it.ev_type = TYPE_KEY;
    it.ev_code = code;
    it.ev_value = val;
    stamp_of(t, it.stamp_sec, it.stamp_usec);
    return it;
  endfunction

  // events that neither arm nor disarm
  function automatic evt_item_t quiet_item();
    evt_item_t it;
    it = random_item();
    it.opcode = OP_EVENT;
    case ($urandom_range(0, 2))
      0: it.ev_type = TYPE_SYNC;
      1: begin
        it.ev_type = TYPE_MISC;
        if (it.ev_code == MISC_SCAN) it.ev_code = 16'd3;
      end
      default: begin
        if (it.ev_type == TYPE_KEY || it.ev_type == TYPE_MISC) it.ev_type = 16'd2;
      end
    endcase
    return it;
  endfunction

  function automatic evt_item_t noise_item();
    evt_item_t it;
    it = random_item();
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        it.opcode = OP_EVENT;
        it.ev_type = TYPE_KEY;
        case ($urandom_range(0, 3))
          0: it.ev_value = 32'sd0;
          1: it.ev_value = VAL_PRESS;
          2: it.ev_value = VAL_REPEAT;
          default: ;
        endcase
      end
      2: begin
        it.opcode = OP_EVENT;
        it.ev_type = TYPE_MISC;
        it.ev_code = MISC_SCAN;
      end
      default: it = quiet_item();
    endcase
    return it;
  endfunction

  function automatic logic [15:0] pool_key();
    return 16'(16 + $urandom_range(0, 23));
  endfunction

  function automatic longint pick_delta();
    longint span;
    span = (cfg_timeout == 0) ? 3 * USEC_PER_SEC : longint'({40'd0, cfg_timeout});
    if (span > 2500000) span = 2500000;
    case ($urandom_range(0, 7))
      0: return 0;
      1: return -longint'($urandom_range(1, 900000));
      2: return longint'({40'd0, cfg_timeout}) + 1 + $urandom_range(0, 40000);
      3: return longint'($urandom_range(2, 9)) * USEC_PER_SEC;
      default: return longint'($urandom_range(0, int'(span)));
    endcase
  endfunction

  task automatic send_item(input evt_item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_d <= it;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    predict_taps(it);
    items_sent++;
  endtask

  task automatic tap_once(input logic [15:0] code, input longint delta,
                          input logic [31:0] scan_dn, input logic [31:0] scan_up,
                          input logic signed [31:0] up_val, input bit extra);
    longint t_up;
    t_up = clock_us + delta;
    send_item(scan_item(scan_dn));
    send_item(key_item(code, VAL_PRESS, clock_us));
    send_item(scan_item(scan_up));
    if (extra) begin
      send_item(key_item(code, VAL_REPEAT, t_up));
      send_item(quiet_item());
    end
    send_item(key_item(code, up_val, t_up));
    clock_us = ((delta > 0) ? t_up : clock_us) + $urandom_range(1000, 3000000);
  endtask

  task automatic tap_plain(input logic [15:0] code, input longint delta);
    logic [31:0] s;
    s = $urandom;
    tap_once(code, delta, s, s, 32'sd0, 1'b0);
  endtask

  // wait out every expected report and any lookup still scanning
  task automatic drain_block();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (tap_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) cfg_timeout = data;
    else cfg_maplen = data[6:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_map_length(input logic [6:0] len);
    drain_block();
    write_reg(CFG_MAP_LENGTH, {17'($urandom), len});
  endtask

  task automatic set_timeout(input logic [23:0] us);
    drain_block();
    write_reg(CFG_TIMEOUT, us);
  endtask

  task automatic test_table_fill();
    evt_item_t it;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it = random_item();
      it.opcode = OP_LOAD;
      it.entry_index = 6'(i);
      it.bind_key = pool_key();
      if ($urandom_range(0, 1) == 0) it.bind_modifier = 16'd0;
      send_item(it);
    end
  endtask

  task automatic test_reset_settings();
    // map length still zero: nothing can hit
    tap_plain(16'd30, 1000);
    set_map_length(7'd64);
    tap_plain(16'd30, 220000);
    tap_plain(16'd30, 220001);
  endtask

  task automatic test_lookup_rules();
    tap_plain(16'd31, 5000);
    tap_plain(16'hFFFF, 5000);
    tap_plain(16'h0000, 5000);
    tap_plain(16'h7777, 5000);
    set_map_length(7'd127);
    tap_plain(16'hFFFF, 5000);
    set_map_length(7'd63);
    tap_plain(16'hFFFF, 5000);
    set_map_length(7'd1);
    tap_plain(16'd30, 5000);
    tap_plain(16'd31, 5000);
    set_map_length(7'd64);
  endtask

  task automatic test_timeout_rules();
    logic [31:0] s;
    evt_item_t   it;
    set_timeout(24'd0);
    tap_plain(16'd30, 50 * USEC_PER_SEC);
    set_timeout(24'hFF_FFFF);
    tap_plain(16'd30, 2 * USEC_PER_SEC);
    tap_plain(16'd30, 1500000);
    tap_plain(16'd31, -400000);
    // seconds field wraps between press and release
    clock_us = longint'({32'd0, 32'hFFFF_FFFF}) * USEC_PER_SEC + 999000;
    tap_plain(16'd30, 5000);
    clock_us = 20 * USEC_PER_SEC;
    s = $urandom;
    it = key_item(16'd30, VAL_PRESS, clock_us);
    it.stamp_usec = 20'hF_FFFF;
    send_item(scan_item(s));
    send_item(it);
    send_item(scan_item(s));
    send_item(key_item(16'd30, 32'sd0, clock_us + USEC_PER_SEC + 300));
    clock_us += 3 * USEC_PER_SEC;
    set_timeout(24'd1);
    tap_plain(16'd30, 1);
    tap_plain(16'd30, 2);
  endtask

  task automatic test_event_filter();
    logic [31:0] s;
    set_timeout(TIMEOUT_RESET);
    s = $urandom;
    tap_once(16'd30, 1000, s, s, 32'sd0, 1'b1);
    tap_once(16'd31, 2000, s, s, -32'sd1, 1'b0);
    tap_once(16'd30, 3000, s, s, 32'sh7FFF_FFFF, 1'b0);
    tap_once(16'd30, 3000, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 1'b0);
    tap_once(16'd30, 3000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b0);
    // release without a scan is dropped; the next armed release counts
    send_item(scan_item(s));
    send_item(key_item(16'd31, VAL_PRESS, clock_us));
    send_item(key_item(16'd31, 32'sd0, clock_us + 500));
    send_item(quiet_item());
    send_item(scan_item(s));
    send_item(key_item(16'd31, 32'sd0, clock_us + 900));
    clock_us += 2 * USEC_PER_SEC;
  endtask

  task automatic test_backpressure();
    drain_block();
    -> hold_ev;
    calm = 1'b1;
    for (int i = 0; i < 16; i++) begin
      tap_plain((i % 3 == 0) ? 16'hFFFF : ((i % 2 == 0) ? 16'd30 : 16'd31), 1000);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_phase(input int unsigned n, input logic [23:0] us,
                                   input logic [6:0] len, input bit quiet);
    int unsigned first;
    int unsigned pick;
    logic [15:0] code;
    logic [31:0] s;
    logic [31:0] s_up;
    logic [31:0] upv;
    evt_item_t   it;
    set_timeout(us);
    write_reg(CFG_MAP_LENGTH, {17'($urandom), len});
    calm = quiet;
    first = items_sent;
    while (items_sent - first < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        case ($urandom_range(0, 9))
          0: code = 16'h0000;
          1: code = 16'hFFFF;
          2: code = 16'($urandom);
          default: code = pool_key();
        endcase
        s = $urandom;
        s_up = ($urandom_range(0, 7) == 0) ? $urandom : s;
        upv = ($urandom_range(0, 5) == 0) ? $urandom : 32'd0;
        tap_once(code, pick_delta(), s, s_up, upv, $urandom_range(0, 4) == 0);
      end else if (pick == 6) begin
        it = random_item();
        it.opcode = OP_LOAD;
        it.bind_key = pool_key();
        if ($urandom_range(0, 1) == 0) it.bind_modifier = 16'd0;
        send_item(it);
      end else begin
        send_item(noise_item());
      end
      if ($urandom_range(0, 39) == 0) begin
        clock_us = longint'($urandom) * USEC_PER_SEC + $urandom_range(0, 999999);
        if (clock_us < 2 * USEC_PER_SEC) clock_us += 2 * USEC_PER_SEC;
      end
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_reset_settings();
    test_lookup_rules();
    test_timeout_rules();
    test_event_filter();
    test_backpressure();
    test_random_phase(40, TIMEOUT_RESET, 7'd64, 1'b0);
    test_random_phase(30, 24'd0, 7'd127, 1'b0);
    test_random_phase(30, 24'($urandom_range(1000, 3000000)), 7'($urandom_range(1, 64)),
                      1'b0);
    test_random_phase(20, 24'hFF_FFFF, 7'd64, 1'b1);
    test_random_phase(20, 24'($urandom_range(1, 2000)), 7'd64, 1'b0);
    evt_valid <= 1'b0;
    waited = 0;
    while (tap_reports_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tap_reports_q.size() != 0) begin
      $display("%0t: %0d expected reports never arrived, first type=%h code=%h value=%b",
               $time, tap_reports_q.size(), tap_reports_q[0].out_type,
               tap_reports_q[0].out_code, tap_reports_q[0].out_value);
      errors += tap_reports_q.size();
    end
    $display("Sent %0d event/load transactions over %0d register writes",
             items_sent, cfg_writes);
    $display("Checked %0d report transactions from %0d predicted taps, %0d errors",
             reports_seen, taps_expected, errors);
    if (errors == 0) begin
      $display("tb_tap_on_lone_release_remapper_core passed");
    end else begin
      $display("tb_tap_on_lone_release_remapper_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/trl_pkg.sv
rtl/core/trl_front.sv
rtl/core/trl_cmd_fifo.sv
rtl/core/trl_back.sv
rtl/core/tap_on_lone_release_remapper_core.sv
tb/sv/tb_tap_on_lone_release_remapper_core.sv
